// ----- src/ttfs_pkg.sv -----
package ttfs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int TAW         = $clog2(TABLE_DEPTH);

  // field widths
  localparam int LEN_W = 6;
  localparam int IDX_W = 5;
  localparam int THR_W = 31;
  localparam int FREQ_W = 32;
  localparam int SMP_W = 32;
  localparam int PST_W = 2;
  localparam int RST_W = 2;

  // stream and config port widths
  localparam int S_DATA_W   = 168;
  localparam int M_DATA_W   = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_CLAMP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HI_CLAMP     = 2'd2;

  // opcodes
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // profiler status codes
  localparam logic [PST_W-1:0] PS_VALID  = 2'd0;
  localparam logic [PST_W-1:0] PS_IGNORE = 2'd1;

  // result status codes
  localparam logic [RST_W-1:0] ST_OK       = 2'd0;
  localparam logic [RST_W-1:0] ST_RETRY    = 2'd1;
  localparam logic [RST_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [RST_W-1:0] ST_PROFILER = 2'd3;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_FIXED = 2'd1,
    K_SCAN  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [RST_W-1:0]    status;
    logic [IDX_W-1:0]    idx;
    logic [THR_W-1:0]    down;
    logic [THR_W-1:0]    up;
    logic [FREQ_W-1:0]   freq;
    logic [THR_W-1:0]    sample;
    logic [FREQ_W-1:0]   cur;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0]  table_length;
    logic [FREQ_W-1:0] lo_clamp;
    logic [FREQ_W-1:0] hi_clamp;
  } cfg_t;

  typedef struct packed {
    logic [THR_W-1:0]  down;
    logic [THR_W-1:0]  up;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/throughput_threshold_freq_select.sv -----
// Threshold-table frequency governor with hysteresis. Load the table first with
// write transfers (tuser high), then program table_length and the optional
// min/max clamps through the config port while the block is idle. Each
// evaluate transfer returns one result: the target frequency and a status
// (ok, retry later, invalid table or throughput, profiler failure); a write
// transfer returns target 0 with status ok. Items that are settled by status
// alone and writes skip the table scan in the back end; an evaluate item with
// a usable sample runs the table scan, which reads one entry per cycle from
// the table memory, then the min and max clamp steps. A two-entry queue sits
// between the classifier and the scan engine, so new transfers are taken
// while a scan runs or a result waits, as long as the queue is not full.
module throughput_threshold_freq_select (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [ttfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_index, entry_down, entry_up, entry_freq, throughput_sample,
  // current_freq, profile_status (lowest bits first), zero pad to 168
  input  logic [ttfs_pkg::S_DATA_W-1:0]     s_tdata,
  // opcode
  input  logic                              s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // target_freq, result_status (lowest bits first), zero pad to 40
  output logic [ttfs_pkg::M_DATA_W-1:0]     m_tdata
);
  import ttfs_pkg::*;

  cfg_t    cfg;
  job_t    in_job;
  job_t    q_job;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // front end: config registers and item classification
  ttfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .job       (in_job),
    .cfg       (cfg)
  );

  // decoupling queue between classification and the scan engine
  ttfs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (in_job),
    .pop  (pop),
    .dout (q_job),
    .stat (q_stat)
  );

  // back end: table memory, scan sequencer, clamps and output register
  ttfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .job      (q_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- src/ttfs_front.sv -----
module ttfs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ttfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ttfs_pkg::S_DATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  input  ttfs_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output ttfs_pkg::job_t                      job,
  output ttfs_pkg::cfg_t                      cfg
);
  import ttfs_pkg::*;

  localparam int OFF_IDX  = 0;
  localparam int OFF_DOWN = OFF_IDX + IDX_W;
  localparam int OFF_UP   = OFF_DOWN + THR_W;
  localparam int OFF_FREQ = OFF_UP + THR_W;
  localparam int OFF_SMP  = OFF_FREQ + FREQ_W;
  localparam int OFF_CUR  = OFF_SMP + SMP_W;
  localparam int OFF_PST  = OFF_CUR + FREQ_W;

  logic [SMP_W-1:0] smp;
  logic [PST_W-1:0] prof;
  logic             len_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_length <= '0;
      cfg.lo_clamp     <= '0;
      cfg.hi_clamp     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_LENGTH: cfg.table_length <= cfg_data[LEN_W-1:0];
        REG_LO_CLAMP:     cfg.lo_clamp     <= cfg_data[FREQ_W-1:0];
        REG_HI_CLAMP:     cfg.hi_clamp     <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  assign smp    = s_tdata[OFF_SMP +: SMP_W];
  assign prof   = s_tdata[OFF_PST +: PST_W];
  assign len_ok = (cfg.table_length >= LEN_W'(2)) &&
                  (32'(cfg.table_length) <= TABLE_DEPTH);

  // classify: writes, items answered from status alone, and table scans
  always_comb begin
    job.idx    = s_tdata[OFF_IDX +: IDX_W];
    job.down   = s_tdata[OFF_DOWN +: THR_W];
    job.up     = s_tdata[OFF_UP +: THR_W];
    job.freq   = s_tdata[OFF_FREQ +: FREQ_W];
    job.sample = smp[THR_W-1:0];
    job.cur    = s_tdata[OFF_CUR +: FREQ_W];
    job.kind   = K_FIXED;
    job.status = ST_OK;
    if (s_tuser == OP_WRITE) begin
      job.kind = K_WRITE;
    end else if (!len_ok) begin
      job.status = ST_INVALID;
    end else if (prof == PS_IGNORE) begin
      job.status = ST_OK;
    end else if (prof != PS_VALID) begin
      job.status = ST_PROFILER;
    end else if (smp == '1) begin
      job.status = ST_RETRY;
    end else if (smp[SMP_W-1]) begin
      job.status = ST_INVALID;
    end else begin
      job.kind = K_SCAN;
    end
  end

endmodule

// ----- src/ttfs_queue.sv -----
module ttfs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ttfs_pkg::job_t    din,
  input  logic              pop,
  output ttfs_pkg::job_t    dout,
  output ttfs_pkg::q_stat_t stat
);
  import ttfs_pkg::*;

  job_t             slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QCW-1:0]   count;

  assign stat.full  = (count == QCW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp + QAW'(1);
      end
      if (pop) begin
        rp <= (rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

// ----- src/ttfs_back.sv -----
module ttfs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ttfs_pkg::cfg_t                cfg,
  input  ttfs_pkg::q_stat_t             q_stat,
  input  ttfs_pkg::job_t                job,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ttfs_pkg::M_DATA_W-1:0] m_tdata
);
  import ttfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MIN  = 5'b00100,
    S_MAX  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state;
  job_t              item;
  entry_t            tbl [TABLE_DEPTH];
  entry_t            rd_data;
  entry_t            prev;
  entry_t            wr_entry;
  logic              mem_we;
  logic              rd_en;
  logic [LEN_W-1:0]  ra;
  logic [LEN_W-1:0]  dk;
  logic              dv;
  logic              lo_hit;
  logic              hi_hit;
  logic              found;
  logic [FREQ_W-1:0] lres;
  logic [FREQ_W-1:0] f0;
  logic [FREQ_W-1:0] flast;
  logic [FREQ_W-1:0] res;
  logic [FREQ_W-1:0] base;
  logic [RST_W-1:0]  rstat;
  logic              band;
  logic              gap;
  logic              keep;
  logic              last;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign mem_we   = pop && (job.kind == K_WRITE) && (32'(job.idx) < TABLE_DEPTH);
  assign rd_en    = (state == S_SCAN) && (ra < cfg.table_length);

  assign wr_entry.down = job.down;
  assign wr_entry.up   = job.up;
  assign wr_entry.freq = job.freq;

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl[TAW'(job.idx)] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= tbl[ra[TAW-1:0]];
    end
  end

  // band and gap tests between the previous entry and the one just read
  assign band = (item.sample >= prev.down) && (item.sample <= prev.up);
  assign gap  = (item.sample > prev.up) && (item.sample < rd_data.down);
  assign keep = (item.cur == prev.freq) || (item.cur == rd_data.freq);
  assign last = (dk == cfg.table_length - LEN_W'(1));

  always_comb begin
    if (lo_hit) begin
      base = f0;
    end else if (hi_hit) begin
      base = flast;
    end else if (found) begin
      base = lres;
    end else begin
      base = item.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
      ra       <= '0;
      dk       <= '0;
    end else begin
      dv <= rd_en;
      if (rd_en) begin
        dk <= ra;
        ra <= ra + LEN_W'(1);
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            ra    <= '0;
            state <= (job.kind == K_SCAN) ? S_SCAN : S_OUT;
          end
        end
        S_SCAN: begin
          if (dv && last) begin
            state <= S_MIN;
          end
        end
        S_MIN: state <= S_MAX;
        S_MAX: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item   <= job;
      found  <= 1'b0;
      lo_hit <= 1'b0;
      hi_hit <= 1'b0;
      res    <= (job.kind == K_WRITE) ? '0 : job.cur;
      rstat  <= job.status;
    end
    if (state == S_SCAN && dv) begin
      prev <= rd_data;
      if (dk == '0) begin
        lo_hit <= (item.sample < rd_data.down);
        f0     <= rd_data.freq;
      end else if (!found && (band || gap)) begin
        found <= 1'b1;
        lres  <= band ? (keep ? item.cur : prev.freq) : rd_data.freq;
      end
      if (last) begin
        hi_hit <= (item.sample > prev.up);
        flast  <= rd_data.freq;
      end
    end
    if (state == S_MIN) begin
      res <= (cfg.lo_clamp != '0 && base < cfg.lo_clamp) ? cfg.lo_clamp : base;
    end
    if (state == S_MAX) begin
      res <= (cfg.hi_clamp != '0 && res > cfg.hi_clamp) ? cfg.hi_clamp : res;
    end
    if (state == S_OUT && out_free) begin
      m_tdata <= {{(M_DATA_W - FREQ_W - RST_W){1'b0}}, rstat, res};
    end
  end

endmodule
